// ----- hw/rtl/prq_pkg.sv -----
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types and constants for the packet ring receive queue: request and
// status codes, controller state encoding and the controller/datapath links.
// ----------------------------------------------------------------------------
package prq_pkg;

    localparam int BYTE_W       = 8;
    localparam int LEN_W        = 16;
    localparam int ADDR_W       = 32;
    localparam int PORT_W       = 16;
    localparam int FILL_LEVEL_W = 12;

    // Request codes
    typedef enum logic [1:0] {
        REQ_WR_HDR  = 2'd0,
        REQ_WR_BYTE = 2'd1,
        REQ_RD_HDR  = 2'd2,
        REQ_RD_BYTE = 2'd3
    } req_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_ROOM = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    // Controller states, one-hot
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_POST = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;  // latch the incoming request
        logic exec;     // carry out the latched request
        logic post;     // close a read transfer (apply skip)
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_post;  // current request ends a read transfer
    } dp_status_t;

endpackage

// ----- hw/rtl/prq_ctrl.sv -----
// ----------------------------------------------------------------------------
// prq_ctrl
// Request sequencer: takes one request, runs it through the datapath, adds a
// closing step when a read transfer ends, then holds the result until taken.
// ----------------------------------------------------------------------------
module prq_ctrl
    import prq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t dp_status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = dp_status.need_post ? S_POST : S_OUT;
            end
            S_POST:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Commands and handshake
    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = (state_reg == S_OUT);
    assign cmd.capture = (state_reg == S_IDLE) && in_valid;
    assign cmd.exec    = (state_reg == S_EXEC);
    assign cmd.post    = (state_reg == S_POST);

endmodule

// ----- hw/rtl/prq_datapath.sv -----
// ----------------------------------------------------------------------------
// prq_datapath
// Byte ring, packet record FIFO, pointers and counters, and the result
// registers. Acts on the commands of the sequencer.
// ----------------------------------------------------------------------------
module prq_datapath
    import prq_pkg::*;
#(
    parameter int RING_DEPTH = 2048,
    parameter int META_DEPTH = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctrl_cmd_t               cmd,
    output dp_status_t              dp_status,
    input  logic                    mode_wr,
    input  logic                    mode_data,
    input  logic [1:0]              req_type,
    input  logic [BYTE_W-1:0]       data_byte,
    input  logic [LEN_W-1:0]        length,
    input  logic [ADDR_W-1:0]       source_address,
    input  logic [PORT_W-1:0]       source_port,
    output logic [1:0]              status,
    output logic [LEN_W-1:0]        read_length,
    output logic [BYTE_W-1:0]       out_byte,
    output logic                    last_byte,
    output logic [ADDR_W-1:0]       from_address,
    output logic [PORT_W-1:0]       from_port,
    output logic [FILL_LEVEL_W-1:0] fill_level
);

    localparam int IDX_W  = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int MIDX_W = (META_DEPTH > 1) ? $clog2(META_DEPTH) : 1;
    localparam int MCNT_W = $clog2(META_DEPTH + 1);
    localparam int CMP_W  = ((FILL_W > LEN_W) ? FILL_W : LEN_W) + 1;
    localparam int TSUM_W = ((IDX_W > LEN_W) ? IDX_W : LEN_W) + 1;
    localparam int MSUM_W = MCNT_W + 1;

    // Storage
    logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
    logic [LEN_W-1:0]  meta_len_mem  [META_DEPTH];
    logic [ADDR_W-1:0] meta_addr_mem [META_DEPTH];
    logic [PORT_W-1:0] meta_port_mem [META_DEPTH];

    // Latched request
    req_t              req_reg;
    logic [BYTE_W-1:0] byte_in_reg;
    logic [LEN_W-1:0]  len_in_reg;
    logic [ADDR_W-1:0] addr_in_reg;
    logic [PORT_W-1:0] port_in_reg;

    // Control state
    logic              mode_reg;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [MCNT_W-1:0] mcount_reg, mcount_next;
    logic [MIDX_W-1:0] mhead_reg, mhead_next;
    logic [LEN_W-1:0]  wr_rem_reg, wr_rem_next;
    logic              wr_acc_reg, wr_acc_next;
    logic [LEN_W-1:0]  rd_rem_reg, rd_rem_next;
    logic [LEN_W-1:0]  skip_reg, skip_next;
    logic              finish_reg, finish_next;

    // Pending record of the packet being written
    logic [LEN_W-1:0]  pend_len_reg;
    logic [ADDR_W-1:0] pend_addr_reg;
    logic [PORT_W-1:0] pend_port_reg;
    logic              pend_load;

    // Result registers
    status_t           status_reg, status_next;
    logic [LEN_W-1:0]  rlen_reg, rlen_next;
    logic              last_reg, last_next;
    logic [ADDR_W-1:0] faddr_reg, faddr_next;
    logic [PORT_W-1:0] fport_reg, fport_next;
    logic              byte_ok_reg, byte_ok_next;
    logic [BYTE_W-1:0] rd_data_reg;

    // Helpers
    logic              ring_we;
    logic              ring_re;
    logic              meta_push;
    logic [MIDX_W-1:0] push_slot;
    logic [MSUM_W-1:0] slot_sum;
    logic [IDX_W-1:0]  head_inc;
    logic [IDX_W-1:0]  tail_inc;
    logic [MIDX_W-1:0] mhead_inc;
    logic [CMP_W-1:0]  room_sum;
    logic [CMP_W-1:0]  plen;
    logic [LEN_W-1:0]  take_dgram;
    logic [LEN_W-1:0]  take_stream;
    logic [TSUM_W-1:0] tail_sum;
    logic [IDX_W-1:0]  tail_fin;
    logic [LEN_W-1:0]  meta_len_head;

    // Wrapping increments and derived values
    assign head_inc  = (head_reg == IDX_W'(RING_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc  = (tail_reg == IDX_W'(RING_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign mhead_inc = (mhead_reg == MIDX_W'(META_DEPTH - 1)) ? '0 : mhead_reg + 1'b1;

    assign slot_sum  = MSUM_W'(mhead_reg) + MSUM_W'(mcount_reg);
    assign push_slot = (slot_sum >= MSUM_W'(META_DEPTH))
                       ? MIDX_W'(slot_sum - MSUM_W'(META_DEPTH)) : MIDX_W'(slot_sum);

    assign room_sum  = CMP_W'(fill_reg) + CMP_W'(len_in_reg);

    // Datagram read: clamp record to fill, then to the requested maximum
    assign meta_len_head = meta_len_mem[mhead_reg];
    assign plen = (CMP_W'(meta_len_head) > CMP_W'(fill_reg))
                  ? CMP_W'(fill_reg) : CMP_W'(meta_len_head);
    assign take_dgram  = (plen < CMP_W'(len_in_reg)) ? LEN_W'(plen) : len_in_reg;
    assign take_stream = (CMP_W'(fill_reg) < CMP_W'(len_in_reg))
                         ? LEN_W'(fill_reg) : len_in_reg;

    // Skip the unread rest of a packet
    assign tail_sum = TSUM_W'(tail_reg) + TSUM_W'(skip_reg);
    assign tail_fin = (tail_sum >= TSUM_W'(RING_DEPTH))
                      ? IDX_W'(tail_sum - TSUM_W'(RING_DEPTH)) : IDX_W'(tail_sum);

    // Request execution
    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        fill_next    = fill_reg;
        mcount_next  = mcount_reg;
        mhead_next   = mhead_reg;
        wr_rem_next  = wr_rem_reg;
        wr_acc_next  = wr_acc_reg;
        rd_rem_next  = rd_rem_reg;
        skip_next    = skip_reg;
        finish_next  = finish_reg;
        status_next  = status_reg;
        rlen_next    = rlen_reg;
        last_next    = last_reg;
        faddr_next   = faddr_reg;
        fport_next   = fport_reg;
        byte_ok_next = byte_ok_reg;
        pend_load    = 1'b0;
        ring_we      = 1'b0;
        ring_re      = 1'b0;
        meta_push    = 1'b0;

        if (cmd.exec)
        begin
            status_next  = ST_OK;
            rlen_next    = '0;
            last_next    = 1'b0;
            faddr_next   = '0;
            fport_next   = '0;
            byte_ok_next = 1'b0;
            finish_next  = 1'b0;
            unique case (req_reg)
                REQ_WR_HDR:
                begin
                    if (len_in_reg == '0 || wr_rem_reg != '0)
                    begin
                        status_next = ST_IGNORED;
                    end
                    else
                    begin
                        wr_rem_next = len_in_reg;
                        if (room_sum > CMP_W'(RING_DEPTH))
                        begin
                            wr_acc_next = 1'b0;
                            status_next = ST_NO_ROOM;
                        end
                        else
                        begin
                            wr_acc_next = 1'b1;
                            pend_load   = 1'b1;
                        end
                    end
                end
                REQ_WR_BYTE:
                begin
                    if (wr_rem_reg == '0)
                    begin
                        status_next = ST_IGNORED;
                    end
                    else
                    begin
                        wr_rem_next = wr_rem_reg - 1'b1;
                        if (wr_acc_reg && fill_reg < FILL_W'(RING_DEPTH))
                        begin
                            ring_we   = 1'b1;
                            head_next = head_inc;
                            fill_next = fill_reg + 1'b1;
                            if (wr_rem_reg == LEN_W'(1) &&
                                mcount_reg < MCNT_W'(META_DEPTH))
                            begin
                                meta_push   = 1'b1;
                                mcount_next = mcount_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            status_next = ST_NO_ROOM;
                        end
                        if (wr_rem_reg == LEN_W'(1))
                        begin
                            wr_acc_next = 1'b0;
                        end
                    end
                end
                REQ_RD_HDR:
                begin
                    if (rd_rem_reg != '0)
                    begin
                        status_next = ST_IGNORED;
                    end
                    else if (fill_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else if (mode_reg && mcount_reg != '0)
                    begin
                        faddr_next  = meta_addr_mem[mhead_reg];
                        fport_next  = meta_port_mem[mhead_reg];
                        mhead_next  = mhead_inc;
                        mcount_next = mcount_reg - 1'b1;
                        rd_rem_next = take_dgram;
                        skip_next   = LEN_W'(plen) - take_dgram;
                        rlen_next   = take_dgram;
                        finish_next = (take_dgram == '0);
                    end
                    else
                    begin
                        rd_rem_next = take_stream;
                        skip_next   = '0;
                        rlen_next   = take_stream;
                    end
                end
                REQ_RD_BYTE:
                begin
                    if (rd_rem_reg == '0 || fill_reg == '0)
                    begin
                        status_next = ST_IGNORED;
                    end
                    else
                    begin
                        ring_re      = 1'b1;
                        byte_ok_next = 1'b1;
                        tail_next    = tail_inc;
                        fill_next    = fill_reg - 1'b1;
                        rd_rem_next  = rd_rem_reg - 1'b1;
                        if (rd_rem_reg == LEN_W'(1))
                        begin
                            last_next   = 1'b1;
                            finish_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    status_next = ST_IGNORED;
                end
            endcase
        end
        else if (cmd.post && finish_reg)
        begin
            // End of transfer: drop what the reader did not take
            tail_next   = tail_fin;
            fill_next   = fill_reg - FILL_W'(skip_reg);
            skip_next   = '0;
            finish_next = 1'b0;
        end
    end

    assign dp_status.need_post = cmd.exec && finish_next;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b1;
            head_reg   <= '0;
            tail_reg   <= '0;
            fill_reg   <= '0;
            mcount_reg <= '0;
            mhead_reg  <= '0;
            wr_rem_reg <= '0;
            wr_acc_reg <= 1'b0;
            rd_rem_reg <= '0;
            skip_reg   <= '0;
            finish_reg <= 1'b0;
        end
        else
        begin
            if (mode_wr)
            begin
                mode_reg <= mode_data;
            end
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            fill_reg   <= fill_next;
            mcount_reg <= mcount_next;
            mhead_reg  <= mhead_next;
            wr_rem_reg <= wr_rem_next;
            wr_acc_reg <= wr_acc_next;
            rd_rem_reg <= rd_rem_next;
            skip_reg   <= skip_next;
            finish_reg <= finish_next;
        end
    end

    // Request capture, pending record and results
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg     <= req_t'(req_type);
            byte_in_reg <= data_byte;
            len_in_reg  <= length;
            addr_in_reg <= source_address;
            port_in_reg <= source_port;
        end
        if (pend_load)
        begin
            pend_len_reg  <= len_in_reg;
            pend_addr_reg <= addr_in_reg;
            pend_port_reg <= port_in_reg;
        end
        status_reg  <= status_next;
        rlen_reg    <= rlen_next;
        last_reg    <= last_next;
        faddr_reg   <= faddr_next;
        fport_reg   <= fport_next;
        byte_ok_reg <= byte_ok_next;
    end

    // Byte ring, registered read port
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[head_reg] <= byte_in_reg;
        end
        if (ring_re)
        begin
            rd_data_reg <= ring_mem[tail_reg];
        end
    end

    // Packet record FIFO
    always_ff @(posedge clk)
    begin
        if (meta_push)
        begin
            meta_len_mem[push_slot]  <= pend_len_reg;
            meta_addr_mem[push_slot] <= pend_addr_reg;
            meta_port_mem[push_slot] <= pend_port_reg;
        end
    end

    // Result outputs
    assign status       = status_reg;
    assign read_length  = rlen_reg;
    assign out_byte     = byte_ok_reg ? rd_data_reg : '0;
    assign last_byte    = last_reg;
    assign from_address = faddr_reg;
    assign from_port    = fport_reg;
    assign fill_level   = FILL_LEVEL_W'(fill_reg);

endmodule

// ----- hw/rtl/packet_ring_receive_queue.sv -----
// ----------------------------------------------------------------------------
// packet_ring_receive_queue
// Receive queue: a byte ring plus a FIFO of packet records (length, source
// address, source port), driven by write/read header and byte requests.
// ----------------------------------------------------------------------------
// Each request yields exactly one result. One request is in flight at a time:
// the result is offered once the request has passed the execute step, and
// when it ends a read transfer also a closing step, since the skip of the
// unread packet rest is applied there. A new request is taken only after the
// result of the last one has been taken; the sequencer sets this pacing. The
// ring and record stores need no clearing after reset, so requests are taken
// right away. datagram_mode is written through the cfg port, which is always
// ready; write it only while the queue is idle.
// fill_level reports the low 12 bits of the byte count after the request.
module packet_ring_receive_queue
    import prq_pkg::*;
#(
    parameter int RING_DEPTH = 2048,
    parameter int META_DEPTH = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // request channel
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              req_type,
    input  logic [BYTE_W-1:0]       data_byte,
    input  logic [LEN_W-1:0]        length,
    input  logic [ADDR_W-1:0]       source_address,
    input  logic [PORT_W-1:0]       source_port,
    // result channel
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [1:0]              status,
    output logic [LEN_W-1:0]        read_length,
    output logic [BYTE_W-1:0]       out_byte,
    output logic                    last_byte,
    output logic [ADDR_W-1:0]       from_address,
    output logic [PORT_W-1:0]       from_port,
    output logic [FILL_LEVEL_W-1:0] fill_level,
    // configuration channel
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic                    cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    // Configuration transfer always taken
    assign cfg_ready = 1'b1;

    // Sequencer
    prq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    // Storage and arithmetic
    prq_datapath #(
        .RING_DEPTH (RING_DEPTH),
        .META_DEPTH (META_DEPTH)
    ) u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .dp_status      (dp_status),
        .mode_wr        (cfg_valid && cfg_ready),
        .mode_data      (cfg_data),
        .req_type       (req_type),
        .data_byte      (data_byte),
        .length         (length),
        .source_address (source_address),
        .source_port    (source_port),
        .status         (status),
        .read_length    (read_length),
        .out_byte       (out_byte),
        .last_byte      (last_byte),
        .from_address   (from_address),
        .from_port      (from_port),
        .fill_level     (fill_level)
    );

endmodule
